### rtl/blru_pkg.sv
// Shared types and constants for the LRU buffer slot map.
`default_nettype none

package blru_pkg;

   // Slots held in the recency chain; slot numbers and register width follow.
   localparam int SLOT_COUNT = 16;
   localparam int SLOT_W     = 4;
   localparam int MAX_W      = 5;

   // File block index width.
   localparam int BLOCK_W    = 12;

   // Stream payload widths; the data widths are padded to whole bytes.
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_USER_W = 2;

   // One entry of the recency chain.
   typedef struct packed {
      logic               valid;
      logic [SLOT_W-1:0]  slot;
      logic [BLOCK_W-1:0] owner;
   } entry_type;

   // Per-cell control from the sequencer.
   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctrl_type;

endpackage : blru_pkg

`default_nettype wire

### rtl/blru_cell.sv
// One recency cell: holds a slot and its owner block, compares, shifts in.
`default_nettype none

module blru_cell (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire blru_pkg::cell_ctrl_type        ctrl,
   input  wire logic [blru_pkg::BLOCK_W-1:0]   lookup_block,
   input  wire blru_pkg::entry_type            prev_entry,
   output blru_pkg::entry_type                 entry,
   output logic                                hit
);

   logic                          valid_ff;
   logic                          valid_in;
   logic [blru_pkg::SLOT_W-1:0]   slot_ff;
   logic [blru_pkg::SLOT_W-1:0]   slot_in;
   logic [blru_pkg::BLOCK_W-1:0]  owner_ff;
   logic [blru_pkg::BLOCK_W-1:0]  owner_in;

   // Take the neighbour's entry on a shift; a clear wins over a shift and drops only the valid bit.
   always_comb begin
      valid_in = valid_ff;
      slot_in  = slot_ff;
      owner_in = owner_ff;
      if (ctrl.clear) begin
         valid_in = 1'b0;
      end else if (ctrl.shift) begin
         valid_in = prev_entry.valid;
         slot_in  = prev_entry.slot;
         owner_in = prev_entry.owner;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff  <= slot_in;
      owner_ff <= owner_in;
   end

   assign entry.valid = valid_ff;
   assign entry.slot  = slot_ff;
   assign entry.owner = owner_ff;
   assign hit         = valid_ff && (owner_ff == lookup_block);

endmodule : blru_cell

`default_nettype wire

### rtl/block_buffer_lru_map.sv
// Top level of the LRU buffer slot map: request/response streams and the chain of cells.
//
// Usage:
//  - req_* carries one file block index per transfer (req_tdata[11:0]).
//  - rsp_* returns one result per request: rsp_tdata holds the slot in [3:0]
//    and the evicted block in [15:4]; rsp_tuser[0] is needs_fill and
//    rsp_tuser[1] is evicted_valid. The evicted block reads zero when no
//    block was evicted.
//  - csr_wr_en/csr_wr_data write max_buffers (0 acts as 1, values above 16
//    saturate to 16) and empty the cache. Write only while the block is idle.
// Pipeline:
//  - A request passes through registers s1 and s2 to the output register.
//  - One request is looked up at a time: the lookup compares the block against
//    every cell of the recency chain, then the commit shifts the chain to put the
//    slot at the most recently used end. The next request may transfer while
//    the previous one commits.
// Reset:
//  - Clears every cell, the allocated count and the pipeline; max_buffers
//    returns to 1. No clearing pass is needed.
// Back-pressure:
//  - A stalled response holds in the output register; one more request can
//    complete its lookup behind it, after which req_tready stays low.
`default_nettype none

module block_buffer_lru_map (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // request: [11:0] block_index
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [blru_pkg::REQ_DATA_W-1:0]   req_tdata,
   // response: [3:0] slot, [15:4] evicted_block
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [blru_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   // response user: [0] needs_fill, [1] evicted_valid
   output logic [blru_pkg::RSP_USER_W-1:0]        rsp_tuser,
   // max_buffers register
   input  wire logic                              csr_wr_en,
   input  wire logic [blru_pkg::MAX_W-1:0]        csr_wr_data
);

   localparam int N  = blru_pkg::SLOT_COUNT;
   localparam int SW = blru_pkg::SLOT_W;
   localparam int BW = blru_pkg::BLOCK_W;
   localparam int MW = blru_pkg::MAX_W;

   // ---------------------------------------------------------------
   // Control and configuration registers
   // ---------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [MW-1:0] max_ff, max_in;
   logic [MW-1:0] count_ff, count_in;

   // Payload registers
   logic [BW-1:0] s1_block_ff, s1_block_in;
   logic [SW-1:0] s2_pos_ff, s2_pos_in;
   logic [SW-1:0] s2_slot_ff, s2_slot_in;
   logic [BW-1:0] s2_block_ff, s2_block_in;
   logic          s2_fill_ff, s2_fill_in;
   logic          s2_fresh_ff, s2_fresh_in;
   logic          s2_evict_ff, s2_evict_in;
   logic [BW-1:0] s2_ev_block_ff, s2_ev_block_in;
   logic [SW-1:0] rsp_slot_ff, rsp_slot_in;
   logic          rsp_fill_ff, rsp_fill_in;
   logic          rsp_evict_ff, rsp_evict_in;
   logic [BW-1:0] rsp_ev_block_ff, rsp_ev_block_in;

   logic req_xfer;
   logic commit;

   // Chain wiring
   blru_pkg::entry_type     cell_entry [N];
   blru_pkg::entry_type     cell_prev  [N];
   blru_pkg::cell_ctrl_type cell_ctrl  [N];
   logic [N-1:0]            hit_vec;
   blru_pkg::entry_type     new_entry;

   // Lookup results
   logic          hit_any;
   logic [SW-1:0] hit_pos;
   logic [SW-1:0] hit_slot;
   logic [SW-1:0] lru_idx;
   logic          fresh;

   // ---------------------------------------------------------------
   // Handshakes: one request in flight, commit when the output is free
   // ---------------------------------------------------------------
   assign commit     = s2_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff && (!s2_valid_ff || commit);
   assign req_xfer   = req_tvalid && req_tready;

   // ---------------------------------------------------------------
   // Recency chain: cell 0 is most recently used
   // ---------------------------------------------------------------
   assign new_entry.valid = 1'b1;
   assign new_entry.slot  = s2_slot_ff;
   assign new_entry.owner = s2_block_ff;

   for (genvar i = 0; i < N; i++) begin : g_cell
      if (i == 0) begin : g_head
         assign cell_prev[i] = new_entry;
      end else begin : g_link
         assign cell_prev[i] = cell_entry[i-1];
      end

      // Shift every cell up to and including the target position.
      assign cell_ctrl[i].clear = csr_wr_en;
      assign cell_ctrl[i].shift = commit && (SW'(i) <= s2_pos_ff);

      blru_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (cell_ctrl[i]),
         .lookup_block (s1_block_ff),
         .prev_entry   (cell_prev[i]),
         .entry        (cell_entry[i]),
         .hit          (hit_vec[i])
      );
   end

   // ---------------------------------------------------------------
   // Lookup: at most one cell hits, so OR the masked fields together
   // ---------------------------------------------------------------
   always_comb begin
      hit_pos  = '0;
      hit_slot = '0;
      for (int i = 0; i < N; i++) begin
         if (hit_vec[i]) begin
            hit_pos  = hit_pos  | SW'(i);
            hit_slot = hit_slot | cell_entry[i].slot;
         end
      end
   end

   assign hit_any = |hit_vec;
   assign lru_idx = SW'(count_ff - MW'(1));
   assign fresh   = !hit_any && (count_ff < max_ff);

   always_comb begin
      s2_block_in    = s1_block_ff;
      s2_fill_in     = !hit_any;
      s2_fresh_in    = fresh;
      s2_evict_in    = !hit_any && !fresh;
      s2_ev_block_in = '0;
      if (hit_any) begin
         s2_pos_in  = hit_pos;
         s2_slot_in = hit_slot;
      end else if (fresh) begin
         // Append a new slot behind the allocated ones.
         s2_pos_in  = SW'(count_ff);
         s2_slot_in = SW'(count_ff);
      end else begin
         // Reuse the least recently used slot and report its old owner.
         s2_pos_in      = lru_idx;
         s2_slot_in     = cell_entry[lru_idx].slot;
         s2_ev_block_in = cell_entry[lru_idx].owner;
      end
   end

   // ---------------------------------------------------------------
   // Next-state logic
   // ---------------------------------------------------------------
   assign s1_block_in = req_tdata[BW-1:0];
   assign s1_valid_in = req_xfer;

   always_comb begin
      if (s1_valid_ff) begin
         s2_valid_in = 1'b1;
      end else if (commit) begin
         s2_valid_in = 1'b0;
      end else begin
         s2_valid_in = s2_valid_ff;
      end
   end

   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_slot_in     = commit ? s2_slot_ff     : rsp_slot_ff;
   assign rsp_fill_in     = commit ? s2_fill_ff     : rsp_fill_ff;
   assign rsp_evict_in    = commit ? s2_evict_ff    : rsp_evict_ff;
   assign rsp_ev_block_in = commit ? s2_ev_block_ff : rsp_ev_block_ff;

   // Clamp the written limit into one to SLOT_COUNT.
   always_comb begin
      max_in = max_ff;
      if (csr_wr_en) begin
         if (csr_wr_data == '0) begin
            max_in = MW'(1);
         end else if (csr_wr_data > MW'(N)) begin
            max_in = MW'(N);
         end else begin
            max_in = csr_wr_data;
         end
      end
   end

   always_comb begin
      if (csr_wr_en) begin
         count_in = '0;
      end else if (commit && s2_fresh_ff) begin
         count_in = count_ff + MW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   // ---------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_ff       <= MW'(1);
         count_ff     <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         max_ff       <= max_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_block_ff <= s1_block_in;
      end
      if (s1_valid_ff) begin
         s2_pos_ff      <= s2_pos_in;
         s2_slot_ff     <= s2_slot_in;
         s2_block_ff    <= s2_block_in;
         s2_fill_ff     <= s2_fill_in;
         s2_fresh_ff    <= s2_fresh_in;
         s2_evict_ff    <= s2_evict_in;
         s2_ev_block_ff <= s2_ev_block_in;
      end
      rsp_slot_ff     <= rsp_slot_in;
      rsp_fill_ff     <= rsp_fill_in;
      rsp_evict_ff    <= rsp_evict_in;
      rsp_ev_block_ff <= rsp_ev_block_in;
   end

   // ---------------------------------------------------------------
   // Outputs
   // ---------------------------------------------------------------
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ev_block_ff, rsp_slot_ff};
   assign rsp_tuser  = {rsp_evict_ff, rsp_fill_ff};

endmodule : block_buffer_lru_map

`default_nettype wire

### rtl/blru_checker.sv
// Port-level checks for the LRU buffer slot map, bound to the top level.
`default_nettype none

module blru_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tvalid,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [blru_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input wire logic [blru_pkg::RSP_USER_W-1:0]   rsp_tuser
);

   // Hold a stalled response.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // A hit never evicts.
   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> !rsp_tuser[1])
      else $error("eviction reported on a hit");

   // Evicted block reads zero unless an eviction is flagged.
   a_ev_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[1] |-> rsp_tdata[15:4] == '0)
      else $error("evicted block not zero");

   // One request at a time: no transfer in the cycle after a transfer.
   a_req_spacing: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted back to back");

   // Nothing comes out straight after reset.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule : blru_checker

bind block_buffer_lru_map blru_checker u_blru_checker (.*);

`default_nettype wire
